>>> hw/rtl/bsc_pkg.sv
// -----------------------------------------------------------------------------
// bsc_pkg: shared types and constants for barometric sensor compensation
// Scaled coefficient set, register indexes, fixed linear maps, divider constants.
// -----------------------------------------------------------------------------
package bsc_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 40;

  // Divider by 2^15-1: number of register stages in the divider
  localparam int unsigned DIV_LAT = 6;
  localparam logic [15:0] DIV_K   = 16'd32767;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_A0_B00  = 3'd0,
    REG_A1_A2   = 3'd1,
    REG_BT1_BT2 = 3'd2,
    REG_BP1_B11 = 3'd3,
    REG_BP2_B12 = 3'd4,
    REG_B21_BP3 = 3'd5
  } cfg_reg_e;

  // Linear maps: scaled = MUL * raw16 + OFS
  localparam logic signed [23:0] KA1_MUL  = 24'sd3608;
  localparam logic signed [31:0] KA1_OFS  = -32'sd1731677965;
  localparam logic signed [23:0] KA2_MUL  = 24'sd16889;
  localparam logic signed [31:0] KA2_OFS  = -32'sd87619360;
  localparam logic signed [23:0] KBT1_MUL = 24'sd2982;
  localparam logic signed [31:0] KBT1_OFS = 32'sd107370906;
  localparam logic signed [23:0] KBT2_MUL = 24'sd329854;
  localparam logic signed [31:0] KBT2_OFS = 32'sd108083093;
  localparam logic signed [23:0] KBP1_MUL = 24'sd19923;
  localparam logic signed [31:0] KBP1_OFS = 32'sd1133836764;
  localparam logic signed [23:0] KB11_MUL = 24'sd2406;
  localparam logic signed [31:0] KB11_OFS = 32'sd118215883;
  localparam logic signed [23:0] KBP2_MUL = 24'sd3079;
  localparam logic signed [31:0] KBP2_OFS = -32'sd181579595;
  localparam logic signed [23:0] KB12_MUL = 24'sd6846;
  localparam logic signed [31:0] KB12_OFS = 32'sd85590281;
  localparam logic signed [23:0] KB21_MUL = 24'sd13836;
  localparam logic signed [31:0] KB21_OFS = 32'sd79333336;
  localparam logic signed [23:0] KBP3_MUL = 24'sd2915;
  localparam logic signed [31:0] KBP3_OFS = 32'sd157155561;

  // Scaled coefficients, each at the width its full range needs
  typedef struct packed {
    logic signed [19:0] a0;
    logic signed [19:0] b00;
    logic signed [31:0] ka1;
    logic signed [30:0] ka2;
    logic signed [28:0] kbt1;
    logic signed [34:0] kbt2;
    logic signed [31:0] kbp1;
    logic signed [28:0] kb11;
    logic signed [29:0] kbp2;
    logic signed [29:0] kb12;
    logic signed [29:0] kb21;
    logic signed [28:0] kbp3;
  } coef_t;

  // Coefficients for all-zero registers
  localparam coef_t COEF_RST = '{
    a0:   20'sd0,
    b00:  20'sd0,
    ka1:  32'(KA1_OFS),
    ka2:  31'(KA2_OFS),
    kbt1: 29'(KBT1_OFS),
    kbt2: 35'(KBT2_OFS),
    kbp1: 32'(KBP1_OFS),
    kb11: 29'(KB11_OFS),
    kbp2: 30'(KBP2_OFS),
    kb12: 30'(KB12_OFS),
    kb21: 30'(KB21_OFS),
    kbp3: 29'(KBP3_OFS)
  };

  function automatic logic signed [47:0] scale_coef(input logic signed [15:0] raw,
                                                    input logic signed [23:0] mul,
                                                    input logic signed [31:0] ofs);
    logic signed [47:0] prod;
    prod = 48'(raw) * 48'(mul);
    return prod + 48'(ofs);
  endfunction

endpackage

>>> hw/rtl/baro_sensor_compensation.sv
// Depth: 23 register stages lie between the start input and done.
// Throughput: one reading pair per cycle; busy stays low, the pipeline never stalls.
// The depth is set by the two divide-by-32767 units (6 stages each) plus the product stages.
// Results are strobed for one cycle on done and cannot be held off by the receiver.
// Reset clears all pipeline valid bits and returns the coefficients to those of all-zero calibration registers.
// -----------------------------------------------------------------------------
// baro_sensor_compensation: fixed-point barometric sensor compensation
// Raw 24-bit pressure/temperature in, 16-bit temperature and 32-bit pressure out.
// -----------------------------------------------------------------------------
module baro_sensor_compensation (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [23:0]                     raw_pressure_i,
  input  logic [23:0]                     raw_temperature_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bsc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bsc_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output logic                            done_o,
  output logic signed [15:0]              temperature_out_o,
  output logic signed [31:0]              pressure_out_o
);
  import bsc_pkg::*;

  coef_t              coef;
  logic               in_xfer;
  logic               temp_v;
  logic signed [15:0] temp_tx;
  logic signed [23:0] temp_dp;

  // Fully pipelined: a new pair can enter every cycle
  assign busy    = 1'b0;
  assign in_xfer = start && !busy;

  bsc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .coef_o      (coef)
  );

  bsc_temp u_temp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_xfer),
    .raw_p_i (raw_pressure_i),
    .raw_t_i (raw_temperature_i),
    .coef_i  (coef),
    .valid_o (temp_v),
    .tx_o    (temp_tx),
    .dp_o    (temp_dp)
  );

  bsc_press u_press (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (temp_v),
    .tx_i    (temp_tx),
    .dp_i    (temp_dp),
    .coef_i  (coef),
    .valid_o (done_o),
    .temp_o  (temperature_out_o),
    .press_o (pressure_out_o)
  );

endmodule

>>> hw/rtl/bsc_cfg.sv
// -----------------------------------------------------------------------------
// bsc_cfg: calibration register file
// Maps each written register straight to its scaled coefficients.
// -----------------------------------------------------------------------------
module bsc_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bsc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bsc_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output bsc_pkg::coef_t                  coef_o
);
  import bsc_pkg::*;

  coef_t             coef_d, coef_q;
  logic signed [15:0] hi16, lo16;

  assign cfg_ready_o = 1'b1;
  assign hi16 = $signed(cfg_wdata_i[31:16]);
  assign lo16 = $signed(cfg_wdata_i[15:0]);

  // Register write decode; unknown indexes are dropped
  always_comb begin
    coef_d = coef_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_A0_B00: begin
          coef_d.a0  = $signed(cfg_wdata_i[39:20]);
          coef_d.b00 = $signed(cfg_wdata_i[19:0]);
        end
        REG_A1_A2: begin
          coef_d.ka1 = 32'(scale_coef(hi16, KA1_MUL, KA1_OFS));
          coef_d.ka2 = 31'(scale_coef(lo16, KA2_MUL, KA2_OFS));
        end
        REG_BT1_BT2: begin
          coef_d.kbt1 = 29'(scale_coef(hi16, KBT1_MUL, KBT1_OFS));
          coef_d.kbt2 = 35'(scale_coef(lo16, KBT2_MUL, KBT2_OFS));
        end
        REG_BP1_B11: begin
          coef_d.kbp1 = 32'(scale_coef(hi16, KBP1_MUL, KBP1_OFS));
          coef_d.kb11 = 29'(scale_coef(lo16, KB11_MUL, KB11_OFS));
        end
        REG_BP2_B12: begin
          coef_d.kbp2 = 30'(scale_coef(hi16, KBP2_MUL, KBP2_OFS));
          coef_d.kb12 = 30'(scale_coef(lo16, KB12_MUL, KB12_OFS));
        end
        REG_B21_BP3: begin
          coef_d.kb21 = 30'(scale_coef(hi16, KB21_MUL, KB21_OFS));
          coef_d.kbp3 = 29'(scale_coef(lo16, KBP3_MUL, KBP3_OFS));
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= COEF_RST;
    end else begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule

>>> hw/rtl/bsc_div.sv
// -----------------------------------------------------------------------------
// bsc_div: pipelined signed divide by 32767, truncating toward zero
// Folds the magnitude by 2^15 = 32767 + 1 repeatedly, then one final fixup.
// -----------------------------------------------------------------------------
module bsc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic signed [63:0] num_i,
  output logic               valid_o,
  output logic signed [63:0] quo_o
);
  import bsc_pkg::*;

  logic [DIV_LAT-1:0] v_q;
  logic [DIV_LAT-2:0] neg_q;

  logic [63:0] d1_mag_d, d1_mag_q;
  logic [49:0] d2_n1_d, d2_n1_q;
  logic [48:0] d2_q1_q;
  logic [34:0] d3_n2_d, d3_n2_q;
  logic [49:0] d3_q2_d, d3_q2_q;
  logic [19:0] d4_n3;
  logic [15:0] d4_n4_d, d4_n4_q;
  logic [4:0]  d4_a4_q;
  logic [49:0] d4_q3_d, d4_q3_q;
  logic [15:0] d5_n5;
  logic        d5_fix;
  logic [5:0]  d5_small;
  logic [49:0] d5_q4_d, d5_q4_q;
  logic signed [63:0] d6_quo_d, d6_quo_q;

  // Stage 1: magnitude
  assign d1_mag_d = num_i[63] ? $unsigned(-num_i) : $unsigned(num_i);
  // Stage 2: first fold
  assign d2_n1_d = 50'(d1_mag_q[63:15]) + 50'(d1_mag_q[14:0]);
  // Stage 3: second fold
  assign d3_n2_d = 35'(d2_n1_q[49:15]) + 35'(d2_n1_q[14:0]);
  assign d3_q2_d = 50'(d2_q1_q) + 50'(d2_n1_q[49:15]);
  // Stage 4: third and fourth folds on narrow values
  assign d4_n3   = 20'(d3_n2_q[34:15]) + 20'(d3_n2_q[14:0]);
  assign d4_n4_d = 16'(d4_n3[19:15]) + 16'(d4_n3[14:0]);
  assign d4_q3_d = d3_q2_q + 50'(d3_n2_q[34:15]);
  // Stage 5: last fold, remainder fixup
  assign d5_n5    = 16'(d4_n4_q[15]) + 16'(d4_n4_q[14:0]);
  assign d5_fix   = (d5_n5 >= DIV_K);
  assign d5_small = 6'(d4_a4_q) + 6'(d4_n4_q[15]) + 6'(d5_fix);
  assign d5_q4_d  = d4_q3_q + 50'(d5_small);
  // Stage 6: restore sign
  assign d6_quo_d = neg_q[DIV_LAT-2] ? -$signed(64'(d5_q4_q)) : $signed(64'(d5_q4_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[DIV_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q    <= {neg_q[DIV_LAT-3:0], num_i[63]};
    d1_mag_q <= d1_mag_d;
    d2_n1_q  <= d2_n1_d;
    d2_q1_q  <= d1_mag_q[63:15];
    d3_n2_q  <= d3_n2_d;
    d3_q2_q  <= d3_q2_d;
    d4_n4_q  <= d4_n4_d;
    d4_a4_q  <= d4_n3[19:15];
    d4_q3_q  <= d4_q3_d;
    d5_q4_q  <= d5_q4_d;
    d6_quo_q <= d6_quo_d;
  end

  assign valid_o = v_q[DIV_LAT-1];
  assign quo_o   = d6_quo_q;

endmodule

>>> hw/rtl/bsc_temp.sv
// -----------------------------------------------------------------------------
// bsc_temp: temperature polynomial pipeline
// Quadratic in dt, divide by 32767, offset and narrowing to 16 bits.
// -----------------------------------------------------------------------------
module bsc_temp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [23:0]         raw_p_i,
  input  logic [23:0]         raw_t_i,
  input  bsc_pkg::coef_t      coef_i,
  output logic                valid_o,
  output logic signed [15:0]  tx_o,
  output logic signed [23:0]  dp_o
);
  import bsc_pkg::*;

  logic signed [23:0] dp, dt;
  logic               t1_v_q, t2_v_q, t3_v_q, t4_v_q;
  logic signed [23:0] t1_dp_q, t2_dp_q, t3_dp_q, t4_dp_q;
  logic signed [23:0] t1_dt_q;
  logic signed [55:0] t1_m1_d, t1_m1_q, t2_m1_q;
  logic signed [54:0] t1_m2_d, t1_m2_q;
  logic signed [40:0] t2_w2a;
  logic signed [63:0] t2_m3_d, t2_m3_q;
  logic signed [63:0] t3_s_d, t3_s_q;
  logic signed [23:0] dp_dly_q [DIV_LAT];
  logic               div_v;
  logic signed [63:0] div_q;
  logic [19:0]        t4_sum;
  logic signed [15:0] t4_tx_q;

  // Offset removal: subtracting 2^23 flips the top bit
  assign dp = $signed({~raw_p_i[23], raw_p_i[22:0]});
  assign dt = $signed({~raw_t_i[23], raw_t_i[22:0]});

  // T1: linear and quadratic products
  assign t1_m1_d = 56'(coef_i.ka1) * 56'(dt);
  assign t1_m2_d = 55'(coef_i.ka2) * 55'(dt);
  // T2: second factor of the quadratic term
  assign t2_w2a  = $signed(t1_m2_q[54:14]);
  assign t2_m3_d = 64'(t2_w2a) * 64'(t1_dt_q);
  // T3: sum into the divider
  assign t3_s_d  = 64'(t2_m1_q) + 64'($signed(t2_m3_q[63:10]));

  bsc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (t3_v_q),
    .num_i   (t3_s_q),
    .valid_o (div_v),
    .quo_o   (div_q)
  );

  // T4: low 20 bits of a0 + (q >>> 19), then >>> 4
  assign t4_sum = div_q[38:19] + coef_i.a0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_v_q <= 1'b0;
      t2_v_q <= 1'b0;
      t3_v_q <= 1'b0;
      t4_v_q <= 1'b0;
    end else begin
      t1_v_q <= valid_i;
      t2_v_q <= t1_v_q;
      t3_v_q <= t2_v_q;
      t4_v_q <= div_v;
    end
  end

  always_ff @(posedge clk_i) begin
    t1_dp_q <= dp;
    t1_dt_q <= dt;
    t1_m1_q <= t1_m1_d;
    t1_m2_q <= t1_m2_d;
    t2_dp_q <= t1_dp_q;
    t2_m1_q <= t1_m1_q;
    t2_m3_q <= t2_m3_d;
    t3_dp_q <= t2_dp_q;
    t3_s_q  <= t3_s_d;
    dp_dly_q[0] <= t3_dp_q;
    for (int i = 1; i < DIV_LAT; i++) begin
      dp_dly_q[i] <= dp_dly_q[i-1];
    end
    t4_dp_q <= dp_dly_q[DIV_LAT-1];
    t4_tx_q <= $signed(t4_sum[19:4]);
  end

  assign valid_o = t4_v_q;
  assign tx_o    = t4_tx_q;
  assign dp_o    = t4_dp_q;

endmodule

>>> hw/rtl/bsc_press.sv
// -----------------------------------------------------------------------------
// bsc_press: pressure polynomial pipeline
// Products in t and dp, wrapped 64-bit sums, divide by 32767, offset b00.
// -----------------------------------------------------------------------------
module bsc_press (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic signed [15:0]  tx_i,
  input  logic signed [23:0]  dp_i,
  input  bsc_pkg::coef_t      coef_i,
  output logic                valid_o,
  output logic signed [15:0]  temp_o,
  output logic signed [31:0]  press_o
);
  import bsc_pkg::*;

  logic p1_v_q, p2_v_q, p3_v_q, p4_v_q, p5_v_q, p6_v_q, p7_v_q;
  logic signed [15:0] p1_tx_q, p2_tx_q, p3_tx_q, p4_tx_q, p5_tx_q, p6_tx_q, p7_tx_q;
  logic signed [23:0] p1_dp_q, p2_dp_q;

  // P1 products
  logic signed [44:0] p1_a_d, p1_a_q;
  logic signed [55:0] p1_b_d, p1_b_q;
  logic signed [50:0] p1_c_d, p1_c_q;
  logic signed [44:0] p1_d_d, p1_d_q;
  logic signed [53:0] p1_e_d, p1_e_q;
  logic signed [45:0] p1_f_d, p1_f_q;
  logic signed [45:0] p1_g_d, p1_g_q;
  logic signed [52:0] p1_h_d, p1_h_q;
  // P2
  logic signed [63:0] p2_w1a_d, p2_w1a_q;
  logic signed [63:0] p2_c2_d, p2_c2_q, p2_d2_d, p2_d2_q, p2_e2_d, p2_e2_q;
  logic signed [61:0] p2_f2_d, p2_f2_q;
  logic signed [63:0] p2_g2_d, p2_g2_q, p2_h2_d, p2_h2_q;
  // P3
  logic signed [63:0] p3_w1a_q, p3_x1_d, p3_x1_q, p3_e2_q;
  logic signed [63:0] p3_f3_d, p3_f3_q, p3_g3_d, p3_g3_q, p3_h3_d, p3_h3_q;
  // P4
  logic signed [63:0] p4_w1a_q, p4_w3a_d, p4_w3a_q, p4_y1_d, p4_y1_q, p4_h3_q;
  // P5, P6
  logic signed [63:0] p5_w1c_d, p5_w1c_q, p5_y2_d, p5_y2_q;
  logic signed [63:0] p6_num_d, p6_num_q;
  // Divider and P7
  logic signed [15:0] tx_dly_q [DIV_LAT];
  logic               div_v;
  logic signed [63:0] div_q;
  logic signed [31:0] p7_p_d, p7_p_q;

  // P1: all first-level products
  assign p1_a_d = 45'(coef_i.kbt1) * 45'(tx_i);
  assign p1_b_d = 56'(coef_i.kbp1) * 56'(dp_i);
  assign p1_c_d = 51'(coef_i.kbt2) * 51'(tx_i);
  assign p1_d_d = 45'(coef_i.kb11) * 45'(tx_i);
  assign p1_e_d = 54'(coef_i.kbp2) * 54'(dp_i);
  assign p1_f_d = 46'(coef_i.kb12) * 46'(tx_i);
  assign p1_g_d = 46'(coef_i.kb21) * 46'(tx_i);
  assign p1_h_d = 53'(coef_i.kbp3) * 53'(dp_i);

  // P2: linear sum and second-level products (kept modulo 2^64)
  assign p2_w1a_d = 64'(p1_a_q) + 64'($signed(p1_b_q[55:5]));
  assign p2_c2_d  = 64'($signed(p1_c_q[50:1])) * 64'(p1_tx_q);
  assign p2_d2_d  = 64'($signed(p1_d_q[44:4])) * 64'(p1_dp_q);
  assign p2_e2_d  = 64'($signed(p1_e_q[53:13])) * 64'(p1_dp_q);
  assign p2_f2_d  = 62'(p1_f_q) * 62'(p1_tx_q);
  assign p2_g2_d  = 64'($signed(p1_g_q[45:6])) * 64'(p1_dp_q);
  assign p2_h2_d  = 64'($signed(p1_h_q[52:12])) * 64'(p1_dp_q);

  // P3: second-order partial sum, third-level products
  assign p3_x1_d = 64'($signed(p2_c2_q[63:8])) + 64'($signed(p2_d2_q[63:1]));
  assign p3_f3_d = 64'($signed(p2_f2_q[61:22])) * 64'(p2_dp_q);
  assign p3_g3_d = 64'($signed(p2_g2_q[63:23])) * 64'(p2_dp_q);
  assign p3_h3_d = 64'($signed(p2_h2_q[63:23])) * 64'(p2_dp_q);

  // P4: finish second-order sum, start third-order sum
  assign p4_w3a_d = p3_x1_q + 64'($signed(p3_e2_q[63:1]));
  assign p4_y1_d  = 64'($signed(p3_f3_q[63:1])) + 64'($signed(p3_g3_q[63:1]));

  // P5, P6: accumulate into divider input
  assign p5_w1c_d = p4_w1a_q + 64'($signed(p4_w3a_q[63:14]));
  assign p5_y2_d  = p4_y1_q + p4_h3_q;
  assign p6_num_d = p5_w1c_q + 64'($signed(p5_y2_q[63:15]));

  bsc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (p6_v_q),
    .num_i   (p6_num_q),
    .valid_o (div_v),
    .quo_o   (div_q)
  );

  // P7: low 32 bits of (q >>> 11) + b00
  assign p7_p_d = $signed(div_q[42:11]) + 32'(coef_i.b00);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
      p4_v_q <= 1'b0;
      p5_v_q <= 1'b0;
      p6_v_q <= 1'b0;
      p7_v_q <= 1'b0;
    end else begin
      p1_v_q <= valid_i;
      p2_v_q <= p1_v_q;
      p3_v_q <= p2_v_q;
      p4_v_q <= p3_v_q;
      p5_v_q <= p4_v_q;
      p6_v_q <= p5_v_q;
      p7_v_q <= div_v;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_tx_q  <= tx_i;
    p1_dp_q  <= dp_i;
    p1_a_q   <= p1_a_d;
    p1_b_q   <= p1_b_d;
    p1_c_q   <= p1_c_d;
    p1_d_q   <= p1_d_d;
    p1_e_q   <= p1_e_d;
    p1_f_q   <= p1_f_d;
    p1_g_q   <= p1_g_d;
    p1_h_q   <= p1_h_d;
    p2_tx_q  <= p1_tx_q;
    p2_dp_q  <= p1_dp_q;
    p2_w1a_q <= p2_w1a_d;
    p2_c2_q  <= p2_c2_d;
    p2_d2_q  <= p2_d2_d;
    p2_e2_q  <= p2_e2_d;
    p2_f2_q  <= p2_f2_d;
    p2_g2_q  <= p2_g2_d;
    p2_h2_q  <= p2_h2_d;
    p3_tx_q  <= p2_tx_q;
    p3_w1a_q <= p2_w1a_q;
    p3_x1_q  <= p3_x1_d;
    p3_e2_q  <= p2_e2_q;
    p3_f3_q  <= p3_f3_d;
    p3_g3_q  <= p3_g3_d;
    p3_h3_q  <= p3_h3_d;
    p4_tx_q  <= p3_tx_q;
    p4_w1a_q <= p3_w1a_q;
    p4_w3a_q <= p4_w3a_d;
    p4_y1_q  <= p4_y1_d;
    p4_h3_q  <= p3_h3_q;
    p5_tx_q  <= p4_tx_q;
    p5_w1c_q <= p5_w1c_d;
    p5_y2_q  <= p5_y2_d;
    p6_tx_q  <= p5_tx_q;
    p6_num_q <= p6_num_d;
    tx_dly_q[0] <= p6_tx_q;
    for (int i = 1; i < DIV_LAT; i++) begin
      tx_dly_q[i] <= tx_dly_q[i-1];
    end
    p7_tx_q <= tx_dly_q[DIV_LAT-1];
    p7_p_q  <= p7_p_d;
  end

  assign valid_o = p7_v_q;
  assign temp_o  = p7_tx_q;
  assign press_o = p7_p_q;

endmodule

>>> tb/bsc_checker.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// bsc_checker: predictor and result checker for baro_sensor_compensation
// Mirrors calibration writes, computes the expected temperature and pressure
// for each accepted reading pair and compares them against the strobed results.
// -----------------------------------------------------------------------------
module bsc_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  input  logic                            busy,
  input  logic [23:0]                     raw_pressure_i,
  input  logic [23:0]                     raw_temperature_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_o,
  input  logic [bsc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bsc_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            done_o,
  input  logic signed [15:0]              temperature_out_o,
  input  logic signed [31:0]              pressure_out_o,
  output int                              fail_count_o,
  output int                              pending_o
);
  import bsc_pkg::*;

  localparam int unsigned NUM_CAL = 6;
  localparam longint OFFSET_24 = 64'sd8388608;
  localparam longint DIV_32767 = 64'sd32767;

  typedef struct {
    logic signed [15:0] temp;
    logic signed [31:0] pres;
  } reading_t;

  logic [CFG_DATA_W-1:0] cal_q [NUM_CAL];
  reading_t              expected_q [$];
  int                    mismatches;

  assign pending_o    = expected_q.size();
  assign fail_count_o = mismatches;

  function automatic longint cal_hi(int unsigned r);
    return longint'($signed(cal_q[r][31:16]));
  endfunction

  function automatic longint cal_lo(int unsigned r);
    return longint'($signed(cal_q[r][15:0]));
  endfunction

  // Fixed-point compensation, all intermediates wrap at 64 bits
  function automatic reading_t compensate(logic [23:0] p_raw, logic [23:0] t_raw);
    reading_t res;
    longint a0, b00, ka1, ka2, kbt1, kbt2, kbp1, kb11, kbp2, kb12, kb21, kbp3;
    longint dp, dt, w1, w2, w3, tx;
    a0   = longint'($signed(cal_q[REG_A0_B00][39:20]));
    b00  = longint'($signed(cal_q[REG_A0_B00][19:0]));
    ka1  = 3608 * cal_hi(REG_A1_A2) - 64'sd1731677965;
    ka2  = 16889 * cal_lo(REG_A1_A2) - 64'sd87619360;
    kbt1 = 2982 * cal_hi(REG_BT1_BT2) + 64'sd107370906;
    kbt2 = 329854 * cal_lo(REG_BT1_BT2) + 64'sd108083093;
    kbp1 = 19923 * cal_hi(REG_BP1_B11) + 64'sd1133836764;
    kb11 = 2406 * cal_lo(REG_BP1_B11) + 64'sd118215883;
    kbp2 = 3079 * cal_hi(REG_BP2_B12) - 64'sd181579595;
    kb12 = 6846 * cal_lo(REG_BP2_B12) + 64'sd85590281;
    kb21 = 13836 * cal_hi(REG_B21_BP3) + 64'sd79333336;
    kbp3 = 2915 * cal_lo(REG_B21_BP3) + 64'sd157155561;
    dp   = longint'({40'd0, p_raw}) - OFFSET_24;
    dt   = longint'({40'd0, t_raw}) - OFFSET_24;

    // temperature
    w1 = ka1 * dt;
    w2 = (ka2 * dt) >>> 14;
    w2 = (w2 * dt) >>> 10;
    w2 = ((w1 + w2) / DIV_32767) >>> 19;
    w1 = (a0 + w2) >>> 4;
    tx = longint'($signed(w1[15:0]));

    // pressure
    w1 = kbt1 * tx;
    w1 = w1 + ((kbp1 * dp) >>> 5);
    w2 = (kbt2 * tx) >>> 1;
    w3 = (w2 * tx) >>> 8;
    w2 = (kb11 * tx) >>> 4;
    w3 = w3 + ((w2 * dp) >>> 1);
    w2 = (kbp2 * dp) >>> 13;
    w3 = w3 + ((w2 * dp) >>> 1);
    w1 = w1 + (w3 >>> 14);

    w2 = kb12 * tx;
    w2 = (w2 * tx) >>> 22;
    w3 = (w2 * dp) >>> 1;
    w2 = (kb21 * tx) >>> 6;
    w2 = (w2 * dp) >>> 23;
    w3 = w3 + ((w2 * dp) >>> 1);
    w2 = (kbp3 * dp) >>> 12;
    w2 = (w2 * dp) >>> 23;
    w3 = w3 + (w2 * dp);
    w1 = w1 + (w3 >>> 15);
    w1 = (w1 / DIV_32767) >>> 11;
    w1 = w1 + b00;

    res.temp = tx[15:0];
    res.pres = w1[31:0];
    return res;
  endfunction

  // Mirror calibration writes, queue predictions, compare results
  always @(posedge clk_i or negedge rst_ni) begin
    reading_t exp_r;
    if (!rst_ni) begin
      foreach (cal_q[i]) cal_q[i] = '0;
      expected_q.delete();
      mismatches = 0;
    end else begin
      if (done_o) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result with no pending reading: temp=%0d pres=%0d",
                     temperature_out_o, pressure_out_o);
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.temp !== temperature_out_o || exp_r.pres !== pressure_out_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: temp exp=%0d got=%0d, pres exp=%0d got=%0d",
                       exp_r.temp, temperature_out_o, exp_r.pres, pressure_out_o);
          end
        end
      end
      if (start && !busy)
        expected_q.push_back(compensate(raw_pressure_i, raw_temperature_i));
      if (cfg_valid_i && cfg_ready_o && cfg_index_i < NUM_CAL) begin
        if (cfg_index_i == REG_A0_B00)
          cal_q[cfg_index_i] = cfg_wdata_i;
        else
          cal_q[cfg_index_i] = {8'd0, cfg_wdata_i[31:0]};
      end
    end
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb: top-level testbench for baro_sensor_compensation
// Drives calibration phases and reading pairs with random gaps; the checker
// predicts every result and the top reports the verdict.
// -----------------------------------------------------------------------------
module tb;
  import bsc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP    = 3'd7;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 30;
  localparam int ITEMS_PER_SET  = 190;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [23:0]           raw_pressure_i = '0;
  logic [23:0]           raw_temperature_i = '0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  done_o;
  logic signed [15:0]    temperature_out_o;
  logic signed [31:0]    pressure_out_o;
  int                    fail_count;
  int                    pending;
  int                    idle_cycles;

  always #5 clk_i = ~clk_i;

  baro_sensor_compensation dut (.*);

  bsc_checker u_checker (
    .clk_i, .rst_ni, .start, .busy, .raw_pressure_i, .raw_temperature_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_wdata_i, .done_o,
    .temperature_out_o, .pressure_out_o,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Watchdog: cycles without any transfer
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[baro_sensor_compensation] ERROR");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // One register write; valid stays high across back-to-back transfers
  task automatic write_cal(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    int gap;
    gap = $urandom_range(0, 6);
    if (gap > 0) begin
      cfg_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // One reading pair; start stays high across back-to-back transfers
  task automatic send_reading(logic [23:0] p, logic [23:0] t, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    raw_pressure_i    <= p;
    raw_temperature_i <= t;
    start             <= 1'b1;
    do @(posedge clk_i); while (busy);
  endtask

  // Wait until every prediction has been matched, then let the pipe settle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_set(logic [39:0] a0b00, logic [31:0] w1, logic [31:0] w2,
                          logic [31:0] w3, logic [31:0] w4, logic [31:0] w5);
    logic [7:0] junk;
    junk = 8'($urandom);
    write_cal(REG_A0_B00, a0b00);
    write_cal(REG_A1_A2, {junk, w1});
    write_cal(REG_BT1_BT2, {junk, w2});
    write_cal(REG_BP1_B11, {junk, w3});
    write_cal(REG_BP2_B12, {junk, w4});
    write_cal(REG_B21_BP3, {junk, w5});
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand32();
    return $urandom;
  endfunction

  task automatic random_readings(int n);
    int gap_mode;
    int gap;
    logic [23:0] p, t;
    gap_mode = $urandom_range(0, 2);
    for (int i = 0; i < n; i++) begin
      gap = (gap_mode == 0) ? 0 : $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) begin
        p = 24'($urandom);
        t = 24'($urandom);
      end else begin
        // realistic region around mid-scale
        p = 24'h800000 + 24'($signed($urandom_range(0, 400000)) - 200000);
        t = 24'h800000 + 24'($signed($urandom_range(0, 400000)) - 200000);
      end
      send_reading(p, t, gap);
    end
  endtask

  initial begin
    logic [23:0] corners [5];
    corners = '{24'h000000, 24'hFFFFFF, 24'h800000, 24'h7FFFFF, 24'h800001};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: corners under reset calibration
    foreach (corners[i])
      foreach (corners[j])
        if (j < 4) send_reading(corners[i], corners[j], 0);
    drain();

    // Out-of-range index must be ignored
    write_cal(CFG_IDX_UNUSED, 40'hFF_FFFF_FFFF);
    write_cal(CFG_IDX_TOP, 40'hFF_FFFF_FFFF);
    cfg_valid_i <= 1'b0;
    send_reading(24'h123456, 24'hABCDEF, 0);
    drain();

    // All-ones calibration, then most-negative, then most-positive coefficients
    load_set(40'hFF_FFFF_FFFF, '1, '1, '1, '1, '1);
    random_readings(ITEMS_PER_SET);
    drain();
    load_set(40'h80000_80000, 32'h8000_8000, 32'h8000_8000, 32'h8000_8000,
             32'h8000_8000, 32'h8000_8000);
    random_readings(ITEMS_PER_SET);
    drain();
    load_set(40'h7FFFF_7FFFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF,
             32'h7FFF_7FFF, 32'h7FFF_7FFF);
    random_readings(ITEMS_PER_SET);
    drain();

    // Random calibration sets, then all-zero calibration
    for (int s = 0; s < 3; s++) begin
      load_set(40'({$urandom, $urandom}), rand32(), rand32(), rand32(), rand32(),
               rand32());
      random_readings(ITEMS_PER_SET);
      drain();
    end
    load_set('0, '0, '0, '0, '0, '0);
    random_readings(ITEMS_PER_SET);
    drain();

    if (fail_count == 0 && pending == 0)
      $display("[baro_sensor_compensation] OK");
    else
      $display("[baro_sensor_compensation] ERROR");
    $finish;
  end

endmodule
